// File: hw/rtl/btb_pkg.sv
// Shared word formats, controller/datapath command and status types, and constants.
package btb_pkg;

   localparam int FIELD_ADDR_BITS = 48;
   localparam int LEN_BITS        = 4;
   localparam int HIST_BITS       = 7;
   localparam int CSR_DATA_BITS   = 32;
   localparam int CSR_ADDR_BITS   = 3;

   // Register index, taken from paddr bit 2 (byte address 4*i).
   localparam logic CSR_INDEX_MODE = 1'b0;

   typedef struct packed {
      logic                       op;
      logic [FIELD_ADDR_BITS-1:0] pc;
      logic [FIELD_ADDR_BITS-1:0] actual_target;
      logic [LEN_BITS-1:0]        instr_length;
      logic                       taken;
   } req_word_type;

   typedef struct packed {
      logic [FIELD_ADDR_BITS-1:0] predicted_target;
      logic                       hit;
      logic                       mispredict;
   } rsp_word_type;

   typedef struct packed {
      logic accept;
      logic start_index;
      logic index_step;
      logic read;
      logic scan_step;
      logic write;
      logic clear_write;
      logic load_out;
   } btb_cmd_type;

   typedef struct packed {
      logic is_lookup;
      logic index_done;
      logic scan_last;
      logic clear_last;
   } btb_status_type;

endpackage

// File: hw/rtl/btb_datapath.sv
// Datapath: set index unit, set memory, way scan, row update and result register.
module btb_datapath #(
   parameter int SETS       = 128,
   parameter int WAYS       = 4,
   parameter int ADDR_BITS  = 48,
   parameter int COUNT_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  btb_pkg::btb_cmd_type   cmd,
   output btb_pkg::btb_status_type status,
   input  btb_pkg::req_word_type  req_word,
   input  logic                   index_mode,
   output btb_pkg::rsp_word_type  rsp_word
);
   import btb_pkg::*;

   localparam int SET_BITS    = $clog2(SETS);
   localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int DIGIT_BITS  = 8;
   localparam int DIGITS      = (ADDR_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int KEY_BITS    = DIGITS * DIGIT_BITS;
   localparam int STEP_BITS   = $clog2(DIGITS + 1);
   localparam int PART_BITS   = SET_BITS + DIGIT_BITS;
   localparam int RECIP_SHIFT = 2 * SET_BITS + DIGIT_BITS;
   localparam int RECIP_BITS  = SET_BITS + DIGIT_BITS + 2;
   localparam int PROD_BITS   = PART_BITS + RECIP_BITS;
   localparam bit IS_POW2     = (SETS & (SETS - 1)) == 0;
   localparam logic [63:0]           RECIP_WIDE = ((64'd1 << RECIP_SHIFT) / 64'(SETS)) + 64'd1;
   localparam logic [RECIP_BITS-1:0] RECIP      = RECIP_BITS'(RECIP_WIDE);
   localparam logic [PART_BITS-1:0]  SETS_PART  = PART_BITS'(SETS);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;

   typedef struct packed {
      logic                  valid;
      logic [ADDR_BITS-1:0]  tag;
      logic [ADDR_BITS-1:0]  target;
      logic [COUNT_BITS-1:0] count;
   } entry_type;

   typedef entry_type [WAYS-1:0] row_type;

   row_type btb_mem [SETS];

   logic [ADDR_BITS-1:0]  pc_ff, pc_in;
   logic [ADDR_BITS-1:0]  actual_ff, actual_in;
   logic [LEN_BITS-1:0]   len_ff, len_in;
   logic [HIST_BITS-1:0]  hist_ff, hist_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [SET_BITS-1:0]   rem_ff, rem_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [SET_BITS-1:0]   clr_ff, clr_in;
   row_type               rd_row_ff;
   logic [WAY_BITS-1:0]   way_ff, way_in;
   logic                  hit_found_ff, hit_found_in;
   logic [WAY_BITS-1:0]   hit_way_ff, hit_way_in;
   logic                  inv_found_ff, inv_found_in;
   logic [WAY_BITS-1:0]   victim_ff, victim_in;
   logic [COUNT_BITS-1:0] best_ff, best_in;
   rsp_word_type          rsp_ff;

   logic [KEY_BITS-1:0]   key_start;
   logic [PART_BITS-1:0]  part;
   logic [PROD_BITS-1:0]  prod;
   logic [DIGIT_BITS-1:0] quot;
   logic [SET_BITS-1:0]   rem_next;
   entry_type             scan_entry;
   entry_type             hit_entry;
   entry_type             fill_entry;
   logic [ADDR_BITS-1:0]  pred;
   logic                  mismatch;
   row_type               new_row;
   logic                  mem_we;
   logic [SET_BITS-1:0]   mem_waddr;
   row_type               mem_wdata;

   // Set index: a mask for a power-of-two set count, else the key is reduced one byte
   // per cycle, the quotient of each step coming from a multiply by the reciprocal.
   always_comb begin
      key_start = KEY_BITS'(ADDR_BITS'(req_word.pc) ^
                            (index_mode ? ADDR_BITS'(hist_ff) : '0));
      part      = {rem_ff, key_ff[KEY_BITS-1 -: DIGIT_BITS]};
      prod      = PROD_BITS'(part) * PROD_BITS'(RECIP);
      quot      = prod[RECIP_SHIFT +: DIGIT_BITS];
      rem_next  = SET_BITS'(part - PART_BITS'(quot) * SETS_PART);
   end

   always_comb begin
      pc_in     = pc_ff;
      actual_in = actual_ff;
      len_in    = len_ff;
      hist_in   = hist_ff;
      key_in    = key_ff;
      rem_in    = rem_ff;
      step_in   = step_ff;
      if (cmd.accept) begin
         pc_in     = ADDR_BITS'(req_word.pc);
         actual_in = ADDR_BITS'(req_word.actual_target);
         len_in    = req_word.instr_length;
         if (!req_word.op) begin
            hist_in = {hist_ff[HIST_BITS-2:0], req_word.taken};
         end
      end
      if (cmd.start_index) begin
         key_in  = key_start;
         rem_in  = IS_POW2 ? key_start[SET_BITS-1:0] : '0;
         step_in = IS_POW2 ? '0 : STEP_BITS'(DIGITS);
      end else if (cmd.index_step) begin
         key_in  = {key_ff[KEY_BITS-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
         rem_in  = rem_next;
         step_in = step_ff - 1'b1;
      end
   end

   // Way scan: first matching way, and the replacement choice.
   always_comb begin
      scan_entry   = rd_row_ff[way_ff];
      way_in       = way_ff;
      hit_found_in = hit_found_ff;
      hit_way_in   = hit_way_ff;
      inv_found_in = inv_found_ff;
      victim_in    = victim_ff;
      best_in      = best_ff;
      if (cmd.read) begin
         way_in       = '0;
         hit_found_in = 1'b0;
         hit_way_in   = '0;
         inv_found_in = 1'b0;
         victim_in    = '0;
         best_in      = COUNT_MAX;
      end else if (cmd.scan_step) begin
         way_in = way_ff + 1'b1;
         if (!hit_found_ff && scan_entry.valid && (scan_entry.tag == pc_ff)) begin
            hit_found_in = 1'b1;
            hit_way_in   = way_ff;
         end
         if (!inv_found_ff) begin
            if (!scan_entry.valid) begin
               inv_found_in = 1'b1;
               victim_in    = way_ff;
            end else if (scan_entry.count < best_ff) begin
               victim_in = way_ff;
               best_in   = scan_entry.count;
            end
         end
      end
   end

   // Row update and prediction.
   always_comb begin
      hit_entry         = rd_row_ff[hit_way_ff];
      fill_entry.valid  = 1'b1;
      fill_entry.tag    = pc_ff;
      fill_entry.target = actual_ff;
      fill_entry.count  = '0;
      pred     = hit_found_ff ? hit_entry.target : ADDR_BITS'(pc_ff + ADDR_BITS'(len_ff));
      mismatch = pred != actual_ff;
      new_row  = rd_row_ff;
      if (hit_found_ff) begin
         if (mismatch) begin
            new_row[hit_way_ff] = fill_entry;
         end else if (hit_entry.count != COUNT_MAX) begin
            new_row[hit_way_ff].count = hit_entry.count + COUNT_BITS'(1);
         end
      end else begin
         new_row[victim_ff] = fill_entry;
      end
   end

   always_comb begin
      clr_in    = cmd.clear_write ? clr_ff + 1'b1 : clr_ff;
      mem_we    = cmd.clear_write | cmd.write;
      mem_waddr = cmd.clear_write ? clr_ff : rem_ff;
      mem_wdata = cmd.clear_write ? '0 : new_row;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         btb_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.read) begin
         rd_row_ff <= btb_mem[rem_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
         step_ff <= '0;
         clr_ff  <= '0;
      end else begin
         hist_ff <= hist_in;
         step_ff <= step_in;
         clr_ff  <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      pc_ff        <= pc_in;
      actual_ff    <= actual_in;
      len_ff       <= len_in;
      key_ff       <= key_in;
      rem_ff       <= rem_in;
      way_ff       <= way_in;
      hit_found_ff <= hit_found_in;
      hit_way_ff   <= hit_way_in;
      inv_found_ff <= inv_found_in;
      victim_ff    <= victim_in;
      best_ff      <= best_in;
      if (cmd.load_out) begin
         rsp_ff.predicted_target <= FIELD_ADDR_BITS'(pred);
         rsp_ff.hit              <= hit_found_ff;
         rsp_ff.mispredict       <= mismatch;
      end
   end

   assign rsp_word          = rsp_ff;
   assign status.is_lookup  = req_word.op;
   assign status.index_done = step_ff == '0;
   assign status.scan_last  = way_ff == WAY_BITS'(WAYS - 1);
   assign status.clear_last = clr_ff == SET_BITS'(SETS - 1);

endmodule

// File: hw/rtl/btb_ctrl.sv
// Controller: sequences the clearing pass, index, read, way scan, write-back and result.
module btb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  btb_pkg::btb_status_type status,
   output btb_pkg::btb_cmd_type    cmd
);
   import btb_pkg::*;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_INDEX = 6'b000100,
      ST_SCAN  = 6'b001000,
      ST_WRITE = 6'b010000,
      ST_HOLD  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.is_lookup) begin
                  cmd.start_index = 1'b1;
                  state_in        = ST_INDEX;
               end
            end
         end
         ST_INDEX: begin
            if (status.index_done) begin
               cmd.read = 1'b1;
               state_in = ST_SCAN;
            end else begin
               cmd.index_step = 1'b1;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hw/rtl/branch_target_buffer_unit.sv
// Top level: set-associative branch target buffer with its register port.
//
// Input words (req_valid/req_stall, req_word) carry either a conditional branch
// outcome (op 0), which shifts into the 7-bit global history and gives no result,
// or an indirect branch (op 1), which looks up pc, answers with one result word
// on rsp_valid/rsp_stall and updates the set. A word is taken when valid is high
// and stall is low.
// A conditional word is taken without leaving the idle state. An indirect word goes
// through the set index reduction (when SETS is not a power of two), the set row
// read, the way scan, the write-back and the load of the result register, and the
// next word is taken after that; the set index is reduced one key byte per cycle and
// the row read from the set memory is scanned one way per cycle.
// One indirect word is in flight at a time; the next word is taken while a result
// still waits in the output register.
// After reset the block clears every set row, one per cycle, and holds req_stall
// high meanwhile; register writes are taken at all times.
// When the receiver stalls, the result waits in the output register; a second
// result waits in the datapath and the input stays stalled until it moves.
// index_mode (register 0, address 0) picks pc or pc xor history for the set index.
module branch_target_buffer_unit #(
   parameter int SETS       = 128,
   parameter int WAYS       = 4,
   parameter int ADDR_BITS  = 48,
   parameter int COUNT_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  btb_pkg::req_word_type                 req_word,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output btb_pkg::rsp_word_type                 rsp_word,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [btb_pkg::CSR_ADDR_BITS-1:0]     paddr,
   input  logic [btb_pkg::CSR_DATA_BITS-1:0]     pwdata,
   output logic [btb_pkg::CSR_DATA_BITS-1:0]     prdata,
   output logic                                  pready
);
   import btb_pkg::*;

   logic           index_mode_ff, index_mode_in;
   logic           csr_write;
   btb_cmd_type    cmd;
   btb_status_type status;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      index_mode_in = index_mode_ff;
      if (csr_write && (paddr[2] == CSR_INDEX_MODE)) begin
         index_mode_in = pwdata[0];
      end
      prdata = (paddr[2] == CSR_INDEX_MODE) ? CSR_DATA_BITS'(index_mode_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_mode_ff <= 1'b0;
      end else begin
         index_mode_ff <= index_mode_in;
      end
   end

   btb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   btb_datapath #(
      .SETS       (SETS),
      .WAYS       (WAYS),
      .ADDR_BITS  (ADDR_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_word   (req_word),
      .index_mode (index_mode_ff),
      .rsp_word   (rsp_word)
   );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for branch_target_buffer_unit: directed and random branch words with a predictor.
module testbench;
   import btb_pkg::*;

   localparam int SETS          = 128;
   localparam int WAYS          = 4;
   localparam int COUNT_MAX     = 255;
   localparam int SETTLE_CYCLES = 12;
   localparam int LIMIT_CYCLES  = 300000;
   localparam int MAX_REPORTS   = 10;
   localparam int POOL_SIZE     = 24;

   localparam logic OP_COND     = 1'b0;
   localparam logic OP_INDIRECT = 1'b1;

   localparam logic [CSR_ADDR_BITS-1:0] ADDR_INDEX_MODE = {CSR_INDEX_MODE, 2'b00};
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_SPARE      = {~CSR_INDEX_MODE, 2'b00};

   localparam int STALL_NONE   = 0;
   localparam int STALL_LIGHT  = 1;
   localparam int STALL_HEAVY  = 2;
   localparam int STALL_TOGGLE = 3;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   req_word_type              req_word;
   logic                      rsp_valid;
   logic                      rsp_stall;
   rsp_word_type              rsp_word;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_BITS-1:0]  paddr;
   logic [CSR_DATA_BITS-1:0]  pwdata;
   logic [CSR_DATA_BITS-1:0]  prdata;
   logic                      pready;

   // Predictor copy of the buffer, the history and the index mode.
   bit                        way_valid  [SETS][WAYS];
   bit [FIELD_ADDR_BITS-1:0]  way_tag    [SETS][WAYS];
   bit [FIELD_ADDR_BITS-1:0]  way_target [SETS][WAYS];
   bit [7:0]                  way_count  [SETS][WAYS];
   bit [HIST_BITS-1:0]        history_q;
   bit                        index_mode_q;

   rsp_word_type              expected_q[$];
   rsp_word_type              checked_word;
   int                        mismatch_count;
   int                        cycle_count;
   int                        burst_left;
   int                        stall_mode;
   int                        stall_left;

   branch_target_buffer_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic bit [FIELD_ADDR_BITS-1:0] rand_addr();
      bit [63:0] v;
      v = {$urandom, $urandom};
      return v[FIELD_ADDR_BITS-1:0];
   endfunction

   function automatic req_word_type make_word(logic op, logic [FIELD_ADDR_BITS-1:0] pc,
                                              logic [FIELD_ADDR_BITS-1:0] target,
                                              logic [LEN_BITS-1:0] len, logic taken);
      req_word_type w;
      w.op            = op;
      w.pc            = pc;
      w.actual_target = target;
      w.instr_length  = len;
      w.taken         = taken;
      return w;
   endfunction

   // Works out what one accepted word does to the buffer and queues its result.
   function automatic void resolve_branch(req_word_type w);
      bit [FIELD_ADDR_BITS-1:0] key;
      bit [FIELD_ADDR_BITS-1:0] pred;
      bit [6:0]                 set_idx;
      int                       hit_way;
      int                       victim;
      bit                       victim_found;
      rsp_word_type             exp_word;
      if (w.op == OP_COND) begin
         history_q = {history_q[HIST_BITS-2:0], w.taken};
         return;
      end
      key     = index_mode_q ?
                (w.pc ^ {{(FIELD_ADDR_BITS-HIST_BITS){1'b0}}, history_q}) : w.pc;
      set_idx = key[6:0];
      hit_way = -1;
      for (int i = 0; i < WAYS; i++) begin
         if (hit_way < 0 && way_valid[set_idx][i] && way_tag[set_idx][i] == w.pc) begin
            hit_way = i;
         end
      end
      if (hit_way >= 0) begin
         pred = way_target[set_idx][hit_way];
         if (way_count[set_idx][hit_way] < COUNT_MAX) begin
            way_count[set_idx][hit_way] = way_count[set_idx][hit_way] + 8'd1;
         end
         // A wrong stored target is replaced, but the old one is what gets answered.
         if (pred != w.actual_target) begin
            way_target[set_idx][hit_way] = w.actual_target;
            way_count[set_idx][hit_way]  = 8'd0;
         end
         exp_word.hit = 1'b1;
      end else begin
         victim       = 0;
         victim_found = 1'b0;
         for (int i = 0; i < WAYS; i++) begin
            if (!victim_found) begin
               if (!way_valid[set_idx][i]) begin
                  victim       = i;
                  victim_found = 1'b1;
               end else if (way_count[set_idx][i] < way_count[set_idx][victim]) begin
                  victim = i;
               end
            end
         end
         way_valid[set_idx][victim]  = 1'b1;
         way_tag[set_idx][victim]    = w.pc;
         way_target[set_idx][victim] = w.actual_target;
         way_count[set_idx][victim]  = 8'd0;
         pred = w.pc + {{(FIELD_ADDR_BITS-LEN_BITS){1'b0}}, w.instr_length};
         exp_word.hit = 1'b0;
      end
      exp_word.predicted_target = pred;
      exp_word.mispredict       = (pred != w.actual_target);
      expected_q.push_back(exp_word);
   endfunction

   // Sends one word in bursts of random length separated by random gaps.
   task automatic send_word(req_word_type w);
      @(negedge clock);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) :
                                                    $urandom_range(1, 10);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      resolve_branch(w);
   endtask

   // Drops valid, waits for every expected result, then lets trailing words finish.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_ADDR_BITS-1:0] addr, logic [CSR_DATA_BITS-1:0] data);
      wait_idle();
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr[2] == CSR_INDEX_MODE) begin
         index_mode_q = data[0];
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Zero length, address wraparound, a hit with the wrong target, history shifts.
   task automatic test_edge_cases();
      bit [FIELD_ADDR_BITS-1:0] top_pc;
      top_pc = {FIELD_ADDR_BITS{1'b1}};
      send_word(make_word(OP_INDIRECT, '0, '0, 4'd0, 1'b0));
      send_word(make_word(OP_INDIRECT, '0, '0, 4'd0, 1'b1));
      send_word(make_word(OP_INDIRECT, top_pc, 48'hE, 4'd15, 1'b0));
      send_word(make_word(OP_INDIRECT, top_pc, 48'h1234, 4'd15, 1'b1));
      send_word(make_word(OP_INDIRECT, top_pc, 48'h1234, 4'd15, 1'b0));
      send_word(make_word(OP_COND, top_pc, top_pc, 4'd15, 1'b1));
      send_word(make_word(OP_COND, '0, '0, 4'd0, 1'b0));
   endtask

   // With all counts equal, the lowest way is the one replaced.
   task automatic test_replacement_ties();
      bit [FIELD_ADDR_BITS-1:0] tie_pc [5];
      for (int i = 0; i < 5; i++) begin
         tie_pc[i]      = rand_addr();
         tie_pc[i][6:0] = 7'd5;
      end
      for (int i = 0; i < 5; i++) begin
         send_word(make_word(OP_INDIRECT, tie_pc[i], rand_addr(),
                             4'($urandom_range(0, 15)), 1'b0));
      end
      send_word(make_word(OP_INDIRECT, tie_pc[0], rand_addr(), 4'd4, 1'b0));
      send_word(make_word(OP_INDIRECT, tie_pc[1], rand_addr(), 4'd4, 1'b0));
      send_word(make_word(OP_INDIRECT, tie_pc[4], rand_addr(), 4'd4, 1'b0));
   endtask

   // Drives one way's count past its maximum; a wrapping count would make it the victim.
   task automatic test_count_saturation();
      bit [FIELD_ADDR_BITS-1:0] sat_pc  [5];
      bit [FIELD_ADDR_BITS-1:0] sat_tgt [5];
      for (int i = 0; i < 5; i++) begin
         sat_pc[i]      = rand_addr();
         sat_pc[i][6:0] = 7'd9;
         sat_tgt[i]     = rand_addr();
      end
      for (int i = 0; i < 4; i++) begin
         send_word(make_word(OP_INDIRECT, sat_pc[i], sat_tgt[i], 4'd2, 1'b0));
      end
      repeat (COUNT_MAX + 1) send_word(make_word(OP_INDIRECT, sat_pc[0], sat_tgt[0], 4'd2, 1'b0));
      for (int i = 1; i < 4; i++) begin
         send_word(make_word(OP_INDIRECT, sat_pc[i], sat_tgt[i], 4'd2, 1'b0));
      end
      send_word(make_word(OP_INDIRECT, sat_pc[4], sat_tgt[4], 4'd2, 1'b0));
      send_word(make_word(OP_INDIRECT, sat_pc[0], sat_tgt[0], 4'd2, 1'b0));
      send_word(make_word(OP_INDIRECT, sat_pc[1], sat_tgt[1], 4'd2, 1'b0));
   endtask

   // History-based indexing, a write to the unused address and a value with only bit 0 kept.
   task automatic test_history_index();
      bit [FIELD_ADDR_BITS-1:0] hist_pc;
      bit [FIELD_ADDR_BITS-1:0] hist_tgt;
      hist_pc  = rand_addr();
      hist_tgt = rand_addr();
      write_register(ADDR_INDEX_MODE, 32'h0000_0001);
      repeat (3) send_word(make_word(OP_COND, rand_addr(), rand_addr(), 4'd1, 1'b1));
      send_word(make_word(OP_INDIRECT, hist_pc, hist_tgt, 4'd3, 1'b0));
      send_word(make_word(OP_INDIRECT, hist_pc, hist_tgt, 4'd3, 1'b0));
      send_word(make_word(OP_COND, rand_addr(), rand_addr(), 4'd1, 1'b0));
      send_word(make_word(OP_INDIRECT, hist_pc, hist_tgt, 4'd3, 1'b0));
      write_register(ADDR_SPARE, 32'h0000_0000);
      send_word(make_word(OP_INDIRECT, hist_pc, hist_tgt, 4'd3, 1'b0));
      write_register(ADDR_INDEX_MODE, 32'hFFFF_FFFE);
      send_word(make_word(OP_INDIRECT, hist_pc, hist_tgt, 4'd3, 1'b0));
      write_register(ADDR_SPARE, 32'hFFFF_FFFF);
      send_word(make_word(OP_INDIRECT, hist_pc, hist_tgt, 4'd3, 1'b0));
   endtask

   // Mostly lookups from a small pool of branches, some sharing a set, plus history
   // updates and fully random lookups as noise.
   task automatic run_random_phase(int num_words, logic [CSR_DATA_BITS-1:0] mode_value);
      bit [FIELD_ADDR_BITS-1:0] pool_pc  [POOL_SIZE];
      bit [FIELD_ADDR_BITS-1:0] pool_tgt [POOL_SIZE];
      req_word_type             w;
      int                       roll;
      int                       idx;
      int                       pick;
      write_register(ADDR_INDEX_MODE, mode_value);
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_pc[i]  = rand_addr();
         pool_tgt[i] = rand_addr();
      end
      // More branches than ways land in one set, so evictions happen.
      for (int i = 8; i < 16; i++) begin
         pool_pc[i][6:0] = pool_pc[0][6:0];
      end
      for (int n = 0; n < num_words; n++) begin
         roll = $urandom_range(0, 99);
         w    = make_word(OP_INDIRECT, rand_addr(), rand_addr(), 4'($urandom_range(0, 15)),
                          1'($urandom_range(0, 1)));
         if (roll < 30) begin
            w.op = OP_COND;
         end else if (roll >= 38) begin
            idx  = $urandom_range(0, POOL_SIZE - 1);
            pick = $urandom_range(0, 9);
            w.pc = pool_pc[idx];
            if (pick < 7) begin
               w.actual_target = pool_tgt[idx];
            end else if (pick < 8) begin
               pool_tgt[idx] = w.actual_target;
            end else begin
               w.actual_target = w.pc + {{(FIELD_ADDR_BITS-LEN_BITS){1'b0}}, w.instr_length};
            end
         end
         send_word(w);
      end
   endtask

   // The receiver switches among stall patterns, including stretches with none.
   initial begin
      rsp_stall  = 1'b0;
      stall_left = 0;
      stall_mode = STALL_NONE;
      forever begin
         @(negedge clock);
         if (stall_left == 0) begin
            stall_mode = $urandom_range(STALL_NONE, STALL_TOGGLE);
            stall_left = $urandom_range(10, 60);
         end
         stall_left--;
         case (stall_mode)
            STALL_NONE: begin
               rsp_stall <= 1'b0;
            end
            STALL_LIGHT: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            STALL_HEAVY: begin
               rsp_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               rsp_stall <= ~rsp_stall;
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("unexpected result word: target %h hit %b mispredict %b",
                        rsp_word.predicted_target, rsp_word.hit, rsp_word.mispredict);
            end
         end else begin
            checked_word = expected_q.pop_front();
            if (rsp_word.predicted_target !== checked_word.predicted_target ||
                rsp_word.hit !== checked_word.hit ||
                rsp_word.mispredict !== checked_word.mispredict) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display({"result mismatch: expected target %h hit %b mispredict %b,",
                            " got target %h hit %b mispredict %b"},
                           checked_word.predicted_target, checked_word.hit,
                           checked_word.mispredict, rsp_word.predicted_target,
                           rsp_word.hit, rsp_word.mispredict);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("branch_target_buffer_unit regression: fail");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_word       = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      mismatch_count = 0;
      cycle_count    = 0;
      burst_left     = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_edge_cases();
      test_replacement_ties();
      test_count_saturation();
      test_history_index();
      run_random_phase(200, 32'hFFFF_FFFF);
      run_random_phase(200, 32'hFFFF_FFFE);
      run_random_phase(150, 32'h0000_0001);
      run_random_phase(150, 32'h0000_0000);
      wait_idle();

      if (mismatch_count == 0) begin
         $display("branch_target_buffer_unit regression: pass");
      end else begin
         $display("branch_target_buffer_unit regression: fail");
      end
      $finish;
   end

endmodule
